>>> rtl/upn_pkg.sv
// ----------------------------------------------------------------------------
// upn_pkg
// Types, character constants and helper functions shared by the URL
// percent normalizer front end, queue and back end.
// ----------------------------------------------------------------------------
package upn_pkg;

  localparam logic [7:0] CH_PCT     = 8'h25;  // '%'
  localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LOW_MIN = 8'h20;  // bytes below this one are always escaped
  localparam logic [7:0] CH_HIGH_MAX = 8'h7A; // highest byte that may pass unescaped
  localparam logic [7:0] DIGIT_BASE = 8'h30;  // '0'
  localparam logic [7:0] ALPHA_BASE = 8'h37;  // 'A' - 10

  localparam int unsigned ENTRY_BYTES = 3;

  // escape decoder state
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } upn_phase_t;

  // one queue entry: up to three decoded bytes, plus the end-of-string mark
  typedef struct packed {
    logic [ENTRY_BYTES-1:0][7:0] bytes;
    logic [1:0]                  cnt;
    logic                        mark;
  } upn_entry_t;

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = c[3:0];
    if (c > CH_NINE) begin
      v = v + 4'd9;
    end
    return v;
  endfunction

  function automatic logic is_unsafe(input logic [7:0] c);
    logic u;
    if (c < CH_LOW_MIN || c > CH_HIGH_MAX) begin
      u = 1'b1;
    end else begin
      case (c) inside
        8'h20, 8'h22, 8'h23, 8'h25, 8'h26, 8'h2B, 8'h2F,
        [8'h3A:8'h40], [8'h5B:8'h5E], 8'h60: u = 1'b1;
        default: u = 1'b0;
      endcase
    end
    return u;
  endfunction

  // upper-case hex digit character for a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] ch;
    if (n < 4'd10) begin
      ch = DIGIT_BASE + {4'h0, n};
    end else begin
      ch = ALPHA_BASE + {4'h0, n};
    end
    return ch;
  endfunction

endpackage

>>> rtl/url_percent_normalizer.sv
// ----------------------------------------------------------------------------
// url_percent_normalizer
// Percent-decodes a URL byte stream and re-escapes unsafe bytes.
// ----------------------------------------------------------------------------
// the decoded bytes of an accepted input word are written into the queue, and
//   the head entry is then registered into the output word
// throughput: one output word per cycle from the output register while out_stall
//   is low and the queue is not empty (an escaped byte gives three words); input
//   words are taken once per cycle while the QUEUE_DEPTH entry queue has room
// reset: clears the escape state, the end-of-string flag, the queue and out_valid
module url_percent_normalizer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       out_last
);
  import upn_pkg::*;

  upn_entry_t push_entry, head;
  logic       push, pop, q_full, q_empty;

  upn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  upn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (push_entry),
    .pop      (pop),
    .rd_entry (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  upn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .out_last   (out_last)
  );

endmodule

>>> rtl/upn_front.sv
// ----------------------------------------------------------------------------
// upn_front
// Accepts raw URL words, runs the percent decoder and writes the decoded
// bytes of each word, with the end-of-string mark, into the queue.
// ----------------------------------------------------------------------------
module upn_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  input  logic               q_full,
  output logic               push,
  output upn_pkg::upn_entry_t push_entry
);
  import upn_pkg::*;

  upn_phase_t phase, phase_next;
  logic [7:0] held, held_next;
  logic       ended, ended_next;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= '0;
      ended <= 1'b0;
    end else begin
      phase <= phase_next;
      held  <= held_next;
      ended <= ended_next;
    end
  end

  always_comb begin
    logic [3:0][7:0] lst;
    logic [1:0]      n;
    logic            alive;
    logic            fresh;
    logic            mark;
    logic [7:0]      v;
    lst        = '0;
    n          = '0;
    alive      = 1'b1;
    fresh      = 1'b0;
    mark       = 1'b0;
    v          = {hex_val(held), hex_val(in_byte)};
    phase_next = phase;
    held_next  = held;
    ended_next = ended;
    push       = 1'b0;
    if (accept) begin
      if (ended) begin
        // words after a zero byte are dropped until the last one
        if (in_last) begin
          ended_next = 1'b0;
        end
      end else begin
        case (phase)
          PH_PCT: begin
            if (is_hex(in_byte)) begin
              held_next  = in_byte;
              phase_next = PH_DIGIT;
            end else begin
              phase_next = PH_IDLE;
              lst[n]     = CH_PCT;
              n          = n + 2'd1;
              fresh      = 1'b1;
            end
          end
          PH_DIGIT: begin
            phase_next = PH_IDLE;
            if (is_hex(in_byte)) begin
              if (v == CH_NUL) begin
                alive = 1'b0;
              end else begin
                lst[n] = v;
                n      = n + 2'd1;
              end
            end else begin
              lst[n] = CH_PCT;
              n      = n + 2'd1;
              lst[n] = held;
              n      = n + 2'd1;
              fresh  = 1'b1;
            end
          end
          default: begin
            phase_next = PH_IDLE;
            fresh      = 1'b1;
          end
        endcase

        // a byte in idle, or one that broke an escape, is looked at as a fresh one
        if (alive && fresh) begin
          if (in_byte == CH_PCT) begin
            phase_next = PH_PCT;
          end else if (in_byte == CH_NUL) begin
            alive = 1'b0;
          end else begin
            lst[n] = in_byte;
            n      = n + 2'd1;
          end
        end

        // flush a pending escape at the end of the url
        if (alive && in_last) begin
          if (phase_next == PH_PCT) begin
            lst[n] = CH_PCT;
            n      = n + 2'd1;
          end else if (phase_next == PH_DIGIT) begin
            lst[n] = CH_PCT;
            n      = n + 2'd1;
            lst[n] = held_next;
            n      = n + 2'd1;
          end
        end

        mark = !alive || in_last;
        push = (n != 2'd0) || mark;
        if (mark) begin
          phase_next = PH_IDLE;
          held_next  = '0;
          ended_next = !in_last;
        end
      end
    end
    push_entry.bytes = lst[ENTRY_BYTES-1:0];
    push_entry.cnt   = n;
    push_entry.mark  = mark;
  end

endmodule

>>> rtl/upn_queue.sv
// ----------------------------------------------------------------------------
// upn_queue
// Short register queue of decoded entries between the front and back end.
// ----------------------------------------------------------------------------
module upn_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  upn_pkg::upn_entry_t wr_entry,
  input  logic               pop,
  output upn_pkg::upn_entry_t rd_entry,
  output logic               full,
  output logic               empty
);
  import upn_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  upn_entry_t    slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/upn_back.sv
// ----------------------------------------------------------------------------
// upn_back
// Walks the head queue entry byte by byte, re-escaping unsafe bytes into
// three characters, and drives the registered output channel.
// ----------------------------------------------------------------------------
module upn_back (
  input  logic               clk,
  input  logic               rst,
  input  upn_pkg::upn_entry_t head,
  input  logic               q_empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               out_last
);
  import upn_pkg::*;

  logic [1:0] byte_idx, byte_idx_next;
  logic [1:0] char_idx, char_idx_next;
  logic       take;
  logic [7:0] cur, ch;
  logic       unsafe_cur, fin_char, fin_entry, ch_valid, ch_last;

  assign take = !q_empty && (!out_valid || !out_stall);
  assign pop  = take && fin_entry;

  always_comb begin
    cur        = head.bytes[byte_idx];
    unsafe_cur = is_unsafe(cur);
    case (char_idx)
      2'd0:    ch = unsafe_cur ? CH_PCT : cur;
      2'd1:    ch = hex_char(cur[7:4]);
      default: ch = hex_char(cur[3:0]);
    endcase
    fin_char = !unsafe_cur || (char_idx == 2'd2);
    if (head.cnt == 2'd0) begin
      // terminator word: carries only the end mark
      ch        = CH_NUL;
      ch_valid  = 1'b0;
      fin_entry = 1'b1;
    end else begin
      ch_valid  = 1'b1;
      fin_entry = fin_char && (byte_idx == head.cnt - 2'd1);
    end
    ch_last = head.mark && fin_entry;

    byte_idx_next = byte_idx;
    char_idx_next = char_idx;
    if (take) begin
      if (fin_entry) begin
        byte_idx_next = '0;
        char_idx_next = '0;
      end else if (fin_char) begin
        byte_idx_next = byte_idx + 2'd1;
        char_idx_next = '0;
      end else begin
        char_idx_next = char_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx  <= '0;
      char_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      byte_idx <= byte_idx_next;
      char_idx <= char_idx_next;
      if (take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte   <= ch;
      byte_valid <= ch_valid;
      out_last   <= ch_last;
    end
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression for the URL percent normalizer. Feeds directed and randomly built
// URL strings, predicts the normalized output stream word by word and checks
// it against the block under several sender and receiver throttling modes.
// ----------------------------------------------------------------------------
module tb;
  import upn_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned MAX_PER_WORD = 7;
  localparam logic [127:0] HEX_UPPER   = "0123456789ABCDEF";

  // {last, byte} pairs for the directed part
  localparam logic [8:0] DIRECTED [25] = '{
    9'h061, 9'h020, 9'h0FF, 9'h07B, 9'h001,  // plain, space, top, above range, control
    9'h025, 9'h034, 9'h031,                  // good escape of 'A'
    9'h025, 9'h07A,                          // percent then non-hex
    9'h025, 9'h065, 9'h025,                  // percent, digit, then a new percent
    9'h032, 9'h066,                          // finishes as a lower-case escape of '/'
    9'h025, 9'h030, 9'h030,                  // escaped zero ends the string
    9'h071, 9'h172,                          // ignored, then the last one clears
    9'h125,                                  // lone percent flushed on last
    9'h025, 9'h162,                          // percent and digit flushed on last
    9'h000, 9'h100                           // raw zero, then cleared by last
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       last;
  } norm_word_t;

  logic       clk;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte    = 8'h00;
  logic       in_last    = 1'b0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       out_last;

  // predictor state
  upn_phase_t esc_phase  = PH_IDLE;
  logic [7:0] held_hex   = 8'h00;
  logic       text_ended = 1'b0;
  norm_word_t step_words [MAX_PER_WORD];
  int         step_count;
  norm_word_t expected_q [$];

  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_req   = 0;
  int hold_left  = 0;

  int fail_count    = 0;
  int live_words    = 0;
  int checked_words = 0;
  int urls_closed   = 0;
  int stall_seen    = 0;
  int unsigned cycle_count = 0;

  url_percent_normalizer DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .out_last   (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("url_percent_normalizer regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic hex_digit_ok(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c <= "9") begin
      v = c - "0";
    end else if (c <= "F") begin
      v = c - "A" + 8'd10;
    end else begin
      v = c - "a" + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic logic needs_escape(input logic [7:0] c);
    logic esc;
    esc = (c < 8'h20) || (c > 8'h7A);
    case (c)
      8'h20, 8'h22, 8'h23, 8'h25, 8'h26, 8'h2B, 8'h2F,
      8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
      8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h60: esc = 1'b1;
      default: ;
    endcase
    return esc;
  endfunction

  function automatic logic [7:0] upper_hex(input logic [3:0] n);
    return HEX_UPPER[8*(15-n) +: 8];
  endfunction

  function automatic void push_char(input logic [7:0] c);
    if (step_count < MAX_PER_WORD) begin
      step_words[step_count] = '{ch: c, valid: 1'b1, last: 1'b0};
      step_count++;
    end
  endfunction

  // escapes one decoded byte; returns 0 when the byte terminates the string
  function automatic logic put_decoded(input logic [7:0] c);
    if (c == CH_NUL) begin
      text_ended = 1'b1;
      return 1'b0;
    end
    if (needs_escape(c)) begin
      push_char(CH_PCT);
      push_char(upper_hex(c[7:4]));
      push_char(upper_hex(c[3:0]));
    end else begin
      push_char(c);
    end
    return 1'b1;
  endfunction

  function automatic void predict_word(input logic [7:0] b, input logic last);
    logic alive;
    logic fresh;
    alive = 1'b1;
    fresh = 1'b0;
    step_count = 0;
    if (text_ended) begin
      if (last) begin
        esc_phase  = PH_IDLE;
        held_hex   = 8'h00;
        text_ended = 1'b0;
      end
      return;
    end
    case (esc_phase)
      PH_PCT: begin
        if (hex_digit_ok(b)) begin
          held_hex  = b;
          esc_phase = PH_DIGIT;
        end else begin
          esc_phase = PH_IDLE;
          alive = put_decoded(CH_PCT);
          fresh = 1'b1;
        end
      end
      PH_DIGIT: begin
        esc_phase = PH_IDLE;
        if (hex_digit_ok(b)) begin
          alive = put_decoded({hex_nibble(held_hex), hex_nibble(b)});
        end else begin
          alive = put_decoded(CH_PCT);
          if (alive) alive = put_decoded(held_hex);
          fresh = 1'b1;
        end
      end
      default: begin
        fresh = 1'b1;
      end
    endcase
    if (alive && fresh) begin
      if (b == CH_PCT) esc_phase = PH_PCT;
      else alive = put_decoded(b);
    end
    // pending escape is flushed literally at the end of the url
    if (alive && last) begin
      if (esc_phase == PH_PCT) begin
        void'(put_decoded(CH_PCT));
      end else if (esc_phase == PH_DIGIT) begin
        void'(put_decoded(CH_PCT));
        void'(put_decoded(held_hex));
      end
    end
    if (!alive || last) begin
      if (step_count == 0) begin
        step_words[0] = '{ch: 8'h00, valid: 1'b0, last: 1'b1};
        step_count = 1;
      end else begin
        step_words[step_count-1].last = 1'b1;
      end
      esc_phase  = PH_IDLE;
      held_hex   = 8'h00;
      text_ended = !last;
    end
    for (int i = 0; i < step_count; i++) expected_q.push_back(step_words[i]);
  endfunction

  // ---------------------------------------------------------------- monitors

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      if (!text_ended) live_words++;
      predict_word(in_byte, in_last);
    end
    if (!rst && in_valid && in_stall) stall_seen++;
  end

  always @(posedge clk) begin : out_check
    norm_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected output word: out_byte %02h byte_valid %0b out_last %0b",
               out_byte, byte_valid, out_last);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        checked_words++;
        if (out_last) urls_closed++;
        if (out_byte !== want.ch) begin
          $error("out_byte: expected %02h, got %02h", want.ch, out_byte);
          fail_count++;
        end
        if (byte_valid !== want.valid) begin
          $error("byte_valid: expected %0b, got %0b", want.valid, byte_valid);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0b, got %0b", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------- sender

  task automatic send_word(input logic [7:0] b, input logic last);
    in_byte  <= b;
    in_last  <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(r) + "0";
    if (r < 16) return 8'(r - 10) + "A";
    return 8'(r - 16) + "a";
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom); while (hex_digit_ok(c));
    return c;
  endfunction

  // one url of plain, random and zero bytes, good and broken escapes, closed by last
  task automatic send_url(input int max_len);
    logic [7:0] url_q [$];
    int len;
    int kind;
    len = $urandom_range(1, max_len);
    while (url_q.size() < len) begin
      kind = $urandom_range(0, 99);
      if (kind < 32) begin
        url_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (kind < 52) begin
        url_q.push_back(CH_PCT);
        url_q.push_back(rand_hex_char());
        url_q.push_back(rand_hex_char());
      end else if (kind < 60) begin
        url_q.push_back(CH_PCT);
        if ($urandom_range(0, 1)) url_q.push_back(rand_hex_char());
        url_q.push_back(rand_non_hex());
      end else if (kind < 67) begin
        url_q.push_back(CH_PCT);
      end else if (kind < 74) begin
        url_q.push_back(rand_hex_char());
      end else if (kind < 96) begin
        url_q.push_back(8'($urandom_range(1, 255)));
      end else if (kind < 98) begin
        url_q.push_back("%");
        url_q.push_back("0");
        url_q.push_back("0");
      end else begin
        url_q.push_back(CH_NUL);
      end
    end
    foreach (url_q[i]) send_word(url_q[i], i == url_q.size() - 1);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    foreach (DIRECTED[i]) send_word(DIRECTED[i][7:0], DIRECTED[i][8]);
    wait_drain();
  endtask

  task automatic run_random(input int words, input int send_idle, input int recv_stall);
    int start;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    start = live_words;
    while (live_words - start < words) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: a stray word with a random end mark
        send_word(8'($urandom), 1'($urandom_range(0, 1)));
      end else begin
        send_url(14);
      end
    end
    wait_drain();
  endtask

  task automatic test_free_running();
    run_random(65, 0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random(65, 88, 0);
  endtask

  task automatic test_receiver_stalls();
    run_random(65, 0, 88);
  endtask

  task automatic test_both_throttled();
    run_random(65, 26, 26);
  endtask

  // long output hold while high bytes keep coming, so the queue backs up
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 300;
    for (int i = 0; i < 40; i++) send_word(8'($urandom_range(8'h80, 8'hFF)), i == 39);
    wait_drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_free_running();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_throttled();
    test_backpressure();
    $display("covered %0d live input words and %0d output words in %0d closed strings",
             live_words, checked_words, urls_closed);
    $display("throttle modes: none, sender, receiver, both, long hold (%0d stalled cycles)",
             stall_seen);
    if (fail_count == 0) begin
      $display("url_percent_normalizer regression: pass");
    end else begin
      $display("url_percent_normalizer regression: fail");
    end
    $finish;
  end

endmodule
